// ----- rtl/core/tasg_pkg.sv -----
// tas gate schedule lookup: shared field widths, command and register codes
// no dependencies

package tasg_pkg;

    localparam int NOW_W       = 63;
    localparam int DUR_W       = 32;
    localparam int CYC_W       = 32;
    localparam int CNT_FIELD_W = 5;
    localparam int IDX_FIELD_W = 4;
    localparam int GBYTE_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [GBYTE_W-1:0] GATE_OPEN_CODE = 8'h01;

    localparam logic [CFG_IDX_W-1:0] CFG_TAS_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

endpackage

// ----- rtl/core/tas_gate_schedule_lookup.sv -----
// tas gate schedule lookup: top level with sequencer and gate control list memory
// depends on tasg_pkg and tasg_mod
//
// usage:
//   input channel (i_in_valid / o_in_ready) carries one command per transfer.
//   a load command writes one list entry; a tick command carries the time in ns.
//   output channel (o_out_valid / i_out_ready) returns one result per command:
//   the gate state after the command and whether the tick recomputed it.
//   configuration port (i_cfg_valid / o_cfg_ready) writes tas_enable (0),
//   cycle time (1) and entry_count (2); it is always ready.
// sequencing:
//   a load, or a tick that does not evaluate, goes from idle straight to the
//   result state. an evaluating tick first runs the serial remainder, then walks
//   list entries over the single memory read port, with a read state and a
//   compare state per entry; the next command is taken once the result has
//   moved into the output register and the sequencer is idle again.
//   one command is in work at a time; o_in_ready is high only when idle.
// reset: gate closed, registers cleared, no result pending. list entries are
//   undefined until loaded.
// stall: a finished result waits in the output register; the next command is
//   still taken, and its result waits until the register is free.

module tas_gate_schedule_lookup #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic [tasg_pkg::NOW_W-1:0]         i_now_ns,
    input  logic [tasg_pkg::IDX_FIELD_W-1:0]   i_entry_index,
    input  logic [tasg_pkg::DUR_W-1:0]         i_entry_duration_ns,
    input  logic [tasg_pkg::GBYTE_W-1:0]       i_entry_gate_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_gate_open,
    output logic                               o_evaluated,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tasg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tasg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tasg_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int RUN_W = DUR_W + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_RD,
        S_CMP,
        S_DONE
    } t_state;

    t_state                 r_state;
    logic                   r_tas_enable;
    logic [CYC_W-1:0]       r_cycle_time;
    logic [CNT_FIELD_W-1:0] r_entry_count;
    logic                   r_gate;
    logic                   r_eval;
    logic [CNT_W-1:0]       r_used;
    logic [CNT_W-1:0]       r_k;
    logic [RUN_W-1:0]       r_run;
    logic                   r_out_valid;
    logic                   r_out_gate;
    logic                   r_out_eval;

    logic [DUR_W:0]         r_mem [MAX_ENTRIES];
    logic [DUR_W:0]         r_rd;

    logic                   w_in_xfer;
    logic                   w_out_free;
    logic                   w_load_ok;
    logic                   w_eval_ok;
    logic                   w_mod_start;
    logic                   w_mod_done;
    logic [CYC_W-1:0]       w_offset;
    logic [RUN_W-1:0]       w_sum;
    logic [CNT_W-1:0]       n_used;
    logic [CNT_W-1:0]       n_k;
    logic [IDX_W-1:0]       w_wr_addr;

    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_load_ok   = 32'(i_entry_index) < MAX_ENTRIES;
    assign w_eval_ok   = r_tas_enable && (r_entry_count != '0) && (r_cycle_time != '0);
    assign w_mod_start = w_in_xfer && (i_command == CMD_TICK) && w_eval_ok;
    assign w_wr_addr   = IDX_W'(i_entry_index);
    assign n_used      = (32'(r_entry_count) > MAX_ENTRIES) ? CNT_W'(MAX_ENTRIES)
                                                          : CNT_W'(r_entry_count);
    assign w_sum       = r_run + RUN_W'(r_rd[DUR_W-1:0]);
    assign n_k         = r_k + 1'b1;

    tasg_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (i_now_ns),
        .i_divisor  (r_cycle_time),
        .o_done     (w_mod_done),
        .o_rem      (w_offset)
    );

    // gate control list: open flag on top of the duration
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && (i_command == CMD_LOAD) && w_load_ok) begin
            r_mem[w_wr_addr] <= {(i_entry_gate_byte == GATE_OPEN_CODE), i_entry_duration_ns};
        end
        r_rd <= r_mem[r_k[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tas_enable  <= 1'b0;
            r_cycle_time  <= '0;
            r_entry_count <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TAS_ENABLE:  r_tas_enable  <= i_cfg_data[0];
                CFG_CYCLE_TIME:  r_cycle_time  <= i_cfg_data[CYC_W-1:0];
                CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[CNT_FIELD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gate      <= 1'b0;
            r_eval      <= 1'b0;
            r_used      <= '0;
            r_k         <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
            r_out_gate  <= 1'b0;
            r_out_eval  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_eval <= 1'b0;
                        r_used <= n_used;
                        r_state <= w_mod_start ? S_MOD : S_DONE;
                    end
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_k     <= '0;
                        r_run   <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_run <= w_sum;
                    if (RUN_W'(w_offset) < w_sum) begin
                        r_gate  <= r_rd[DUR_W];
                        r_eval  <= 1'b1;
                        r_state <= S_DONE;
                    end else if (n_k == r_used) begin
                        r_gate  <= 1'b0;
                        r_eval  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_k     <= n_k;
                        r_state <= S_RD;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_gate  <= r_gate;
                        r_out_eval  <= r_eval;
                        r_state     <= S_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_gate_open = r_out_gate;
    assign o_evaluated = r_out_eval;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- rtl/core/tasg_mod.sv -----
// tas gate schedule lookup: bit-serial remainder unit, one quotient bit per cycle
// depends on tasg_pkg

module tasg_mod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [tasg_pkg::NOW_W-1:0]   i_dividend,
    input  logic [tasg_pkg::CYC_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [tasg_pkg::CYC_W-1:0]   o_rem
);
    import tasg_pkg::*;

    localparam int STEP_W = $clog2(NOW_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [NOW_W-1:0]  r_dvd;
    logic [CYC_W-1:0]  r_rem;

    logic [CYC_W:0]    w_trial;
    logic [CYC_W:0]    w_diff;
    logic [CYC_W-1:0]  n_rem;

    // shared subtract and compare
    assign w_trial = {r_rem, r_dvd[NOW_W-1]};
    assign w_diff  = w_trial - {1'b0, i_divisor};
    assign n_rem   = (w_trial >= {1'b0, i_divisor}) ? w_diff[CYC_W-1:0] : w_trial[CYC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NOW_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[NOW_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/core/tasg_chk.sv -----
// tas gate schedule lookup: port-level checker and its bind to the top level
// depends on tas_gate_schedule_lookup

module tasg_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input logic o_gate_open,
    input logic o_evaluated
);

    // one command in work at a time
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again right after a transfer");

    // no result can appear in the cycle a command is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !o_out_valid) |=> !o_out_valid)
        else $error("result shown without work cycles");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_gate_open) && $stable(o_evaluated)))
        else $error("stalled result changed");

endmodule

bind tas_gate_schedule_lookup tasg_chk u_tasg_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_gate_open (o_gate_open),
    .o_evaluated (o_evaluated)
);

// ----- sim/tb.sv -----
// testbench for tas_gate_schedule_lookup: gate list loads and time ticks checked
// against an in-bench gate schedule predictor, with bursty input and stalled output
// depends on tasg_pkg and tas_gate_schedule_lookup
`timescale 1ns / 100ps

module tb;
    import tasg_pkg::*;

    localparam int MAX_ENTRIES = 16;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS = 60;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [NOW_W-1:0] NOW_MAX = {NOW_W{1'b1}};

    typedef struct packed {
        logic                   command;
        logic [NOW_W-1:0]       now_ns;
        logic [IDX_FIELD_W-1:0] entry;
        logic [DUR_W-1:0]       dur_ns;
        logic [GBYTE_W-1:0]     gate_byte;
    } t_gcl_cmd;

    typedef struct packed {
        logic gate_open;
        logic evaluated;
    } t_gate_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    logic                   i_command = CMD_TICK;
    logic [NOW_W-1:0]       i_now_ns = '0;
    logic [IDX_FIELD_W-1:0] i_entry_index = '0;
    logic [DUR_W-1:0]       i_entry_duration_ns = '0;
    logic [GBYTE_W-1:0]     i_entry_gate_byte = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b0;
    logic                   o_gate_open;
    logic                   o_evaluated;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    // predictor state
    logic [DUR_W-1:0]       gcl_duration [MAX_ENTRIES];
    logic                   gcl_open [MAX_ENTRIES];
    logic                   gate_now = 1'b0;
    logic                   shaper_on = 1'b0;
    logic [CYC_W-1:0]       cycle_len = '0;
    logic [CNT_FIELD_W-1:0] list_len = '0;

    // stimulus planning state, ahead of the predictor
    logic [DUR_W-1:0]       plan_duration [MAX_ENTRIES];
    logic [CYC_W-1:0]       plan_cycle = '0;
    int                     plan_used = 0;

    t_gcl_cmd     cmd_backlog[$];
    t_gate_result gate_expect[$];

    int   n_issued = 0;
    int   n_results = 0;
    int   n_accepted = 0;
    int   n_fail = 0;
    int   idle_cycles = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic in_fire = 1'b0;
    logic [5:0] rx_count = '0;
    logic [1:0] rx_mode = '0;

    tas_gate_schedule_lookup #(.MAX_ENTRIES(MAX_ENTRIES)) uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_command           (i_command),
        .i_now_ns            (i_now_ns),
        .i_entry_index       (i_entry_index),
        .i_entry_duration_ns (i_entry_duration_ns),
        .i_entry_gate_byte   (i_entry_gate_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_gate_open         (o_gate_open),
        .o_evaluated         (o_evaluated),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_gate_result gate_lookup(t_gcl_cmd c);
        t_gate_result r;
        logic [63:0]  offset;
        logic [63:0]  run_end;
        logic         found;
        int           used;
        int           k;
        r.evaluated = 1'b0;
        if (c.command == CMD_LOAD) begin
            gcl_duration[c.entry] = c.dur_ns;
            gcl_open[c.entry] = (c.gate_byte == GATE_OPEN_CODE);
        end else if (shaper_on && list_len != 0 && cycle_len != 0) begin
            used = (list_len > MAX_ENTRIES) ? MAX_ENTRIES : int'(list_len);
            offset = {1'b0, c.now_ns} % {32'b0, cycle_len};
            run_end = '0;
            found = 1'b0;
            for (k = 0; k < used; k++) begin
                if (!found) begin
                    run_end = run_end + {32'b0, gcl_duration[k]};
                    if (offset < run_end) begin
                        gate_now = gcl_open[k];
                        found = 1'b1;
                    end
                end
            end
            if (!found)
                gate_now = 1'b0;
            r.evaluated = 1'b1;
        end
        r.gate_open = gate_now;
        return r;
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TAS_ENABLE:  shaper_on = data[0];
            CFG_CYCLE_TIME:  cycle_len = data;
            CFG_ENTRY_COUNT: list_len = data[CNT_FIELD_W-1:0];
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        logic [CNT_FIELD_W-1:0] cnt;
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        if (idx == CFG_CYCLE_TIME)
            plan_cycle = data;
        if (idx == CFG_ENTRY_COUNT) begin
            cnt = data[CNT_FIELD_W-1:0];
            plan_used = (cnt > MAX_ENTRIES) ? MAX_ENTRIES : int'(cnt);
        end
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic queue_tick(input logic [NOW_W-1:0] t);
        t_gcl_cmd c;
        c = '0;
        c.command = CMD_TICK;
        c.now_ns = t;
        c.entry = IDX_FIELD_W'($urandom);
        c.dur_ns = $urandom;
        c.gate_byte = GBYTE_W'($urandom);
        cmd_backlog.push_back(c);
        n_issued++;
    endtask

    task automatic queue_load(input int idx, input logic [DUR_W-1:0] dur,
                              input logic [GBYTE_W-1:0] gbyte);
        t_gcl_cmd c;
        c.command = CMD_LOAD;
        c.now_ns = NOW_W'({$urandom, $urandom});
        c.entry = IDX_FIELD_W'(idx);
        c.dur_ns = dur;
        c.gate_byte = gbyte;
        plan_duration[idx] = dur;
        cmd_backlog.push_back(c);
        n_issued++;
    endtask

    task automatic drain();
        while (n_results < n_issued)
            @(negedge i_clk);
    endtask

    // times spread over the full range, near zero, and around entry boundaries
    function automatic logic [NOW_W-1:0] pick_now();
        logic [63:0] span;
        logic [63:0] base;
        int          j;
        int          k;
        if (plan_used == 0 || plan_cycle == 0 || $urandom_range(0, 3) == 0)
            return NOW_W'({$urandom, $urandom});
        if ($urandom_range(0, 3) == 0)
            return NOW_W'($urandom_range(0, 1000));
        j = $urandom_range(0, plan_used - 1);
        span = '0;
        for (k = 0; k <= j; k++)
            span = span + {32'b0, plan_duration[k]};
        base = 64'($urandom_range(0, 32'h3FFF_FFFF)) * {32'b0, plan_cycle};
        return NOW_W'(base + span + 64'($signed($urandom_range(0, 2)) - 1));
    endfunction

    function automatic logic [DUR_W-1:0] pick_duration();
        logic [63:0] lim;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return $urandom;
            default: begin
                lim = {32'b0, plan_cycle} * 2 / ((plan_used == 0) ? 1 : plan_used);
                if (lim > 64'hFFFF_FFFF)
                    lim = 64'hFFFF_FFFF;
                return (plan_cycle == 0) ? $urandom_range(0, 1000) : $urandom_range(0, lim[31:0]);
            end
        endcase
    endfunction

    // sender: bursts of random length, random gaps between them
    always @(negedge i_clk) begin : driver
        t_gcl_cmd cur;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_fire) begin
            i_in_valid <= 1'b1;
        end else if (gap_left != 0) begin
            i_in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() != 0) begin
            cur = cmd_backlog.pop_front();
            i_in_valid <= 1'b1;
            i_command <= cur.command;
            i_now_ns <= cur.now_ns;
            i_entry_index <= cur.entry;
            i_entry_duration_ns <= cur.dur_ns;
            i_entry_gate_byte <= cur.gate_byte;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 30);
                gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150)
                                                        : $urandom_range(0, 4);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // receiver: rotating stall patterns plus one long hold-off to back up the input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && n_accepted >= 200 && cmd_backlog.size() > 20) begin
            i_out_ready <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            if (rx_count == 0)
                rx_mode <= 2'($urandom_range(0, 3));
            rx_count <= rx_count + 1'b1;
            case (rx_mode)
                2'd0:    i_out_ready <= 1'b1;
                2'd1:    i_out_ready <= ($urandom_range(0, 3) != 0);
                2'd2:    i_out_ready <= rx_count[2];
                default: i_out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        t_gate_result want;
        t_gcl_cmd     got;
        in_fire <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                n_results++;
                if (gate_expect.size() == 0) begin
                    $display("%0t extra result: expected none, got gate_open=%0b evaluated=%0b",
                             $time, o_gate_open, o_evaluated);
                    n_fail++;
                end else begin
                    want = gate_expect.pop_front();
                    if (o_gate_open !== want.gate_open) begin
                        $display("%0t gate_open mismatch: expected %0b, got %0b",
                                 $time, want.gate_open, o_gate_open);
                        n_fail++;
                    end
                    if (o_evaluated !== want.evaluated) begin
                        $display("%0t evaluated mismatch: expected %0b, got %0b",
                                 $time, want.evaluated, o_evaluated);
                        n_fail++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                got.command = i_command;
                got.now_ns = i_now_ns;
                got.entry = i_entry_index;
                got.dur_ns = i_entry_duration_ns;
                got.gate_byte = i_entry_gate_byte;
                gate_expect.push_back(gate_lookup(got));
                n_accepted++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("tas_gate_schedule_lookup regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                     k;
        int                     p;
        int                     n;
        logic [GBYTE_W-1:0]     gbyte;
        logic [DUR_W-1:0]       dur;
        logic [CYC_W-1:0]       cyc;
        logic [CNT_FIELD_W-1:0] cnt;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // shaping off after reset: gate stays closed
        queue_tick('0);
        queue_tick(NOW_MAX);
        for (k = 0; k < MAX_ENTRIES; k++) begin
            case (k)
                2:       gbyte = 8'hFF;
                4:       gbyte = 8'h81;
                6:       gbyte = 8'h03;
                default: gbyte = (k % 2) ? GATE_OPEN_CODE : GBYTE_W'(k * 8'h11);
            endcase
            dur = (k == 0) ? '0 : (k == 3) ? 32'hFFFF_FFFF : DUR_W'(10 * k);
            queue_load(k, dur, gbyte);
        end
        drain();

        write_reg(CFG_TAS_ENABLE, 32'd1);
        write_reg(CFG_CYCLE_TIME, 32'd100);
        write_reg(CFG_ENTRY_COUNT, 32'd4);
        write_reg(CFG_UNUSED, $urandom);
        queue_tick('0);
        queue_tick(63'd9);
        queue_tick(63'd10);
        queue_tick(63'd30);
        drain();

        // offset past the last entry closes the gate
        write_reg(CFG_ENTRY_COUNT, 32'd2);
        queue_tick(63'd150);
        drain();

        // entry count above the list size saturates
        write_reg(CFG_ENTRY_COUNT, 32'd31);
        write_reg(CFG_CYCLE_TIME, 32'hFFFF_FFFF);
        queue_tick(63'hFFFF_FFFE);
        queue_tick(NOW_MAX);
        drain();
        write_reg(CFG_CYCLE_TIME, 32'd1);
        queue_tick(NOW_W'({$urandom, $urandom}));
        drain();

        // zero cycle time, zero entries, shaping off: gate held
        write_reg(CFG_CYCLE_TIME, '0);
        queue_tick(63'd5);
        drain();
        write_reg(CFG_CYCLE_TIME, 32'd100);
        write_reg(CFG_ENTRY_COUNT, '0);
        queue_tick(63'd5);
        drain();
        write_reg(CFG_ENTRY_COUNT, 32'd4);
        write_reg(CFG_TAS_ENABLE, '0);
        queue_tick(63'd15);
        drain();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 7))
                0:       cyc = 32'd1;
                1:       cyc = 32'hFFFF_FFFF;
                2:       cyc = '0;
                3:       cyc = $urandom;
                default: cyc = $urandom_range(2, 5000);
            endcase
            case ($urandom_range(0, 9))
                0:       cnt = '0;
                1:       cnt = CNT_FIELD_W'($urandom_range(17, 31));
                2:       cnt = CNT_FIELD_W'(MAX_ENTRIES);
                default: cnt = CNT_FIELD_W'($urandom_range(1, MAX_ENTRIES));
            endcase
            write_reg(CFG_TAS_ENABLE, {31'($urandom), 1'($urandom_range(0, 9) != 0)});
            write_reg(CFG_CYCLE_TIME, cyc);
            write_reg(CFG_ENTRY_COUNT, {27'($urandom), cnt});
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 3) == 0)
                    queue_load($urandom_range(0, MAX_ENTRIES - 1), pick_duration(),
                               $urandom_range(0, 1) ? GATE_OPEN_CODE : GBYTE_W'($urandom));
                else
                    queue_tick(pick_now());
            end
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (n_fail == 0)
            $display("tas_gate_schedule_lookup regression: pass");
        else
            $display("tas_gate_schedule_lookup regression: fail");
        $finish;
    end

endmodule

// ----- tas_gate_schedule_lookup.f -----
rtl/core/tasg_pkg.sv
rtl/core/tasg_mod.sv
rtl/core/tas_gate_schedule_lookup.sv
rtl/core/tasg_chk.sv
sim/tb.sv
